// ===== hw/rtl/cne_pkg.sv =====
package cne_pkg;

    localparam int KEY_W      = 16;
    localparam int MAX_KEYS_D = 16;

    typedef enum logic [1:0] {
        REG_ENABLED   = 2'd0,
        REG_TYPE      = 2'd1,
        REG_SPREAD    = 2'd2,
        REG_INVERSION = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic       enabled;
        logic [2:0] ctype;
        logic [1:0] spread;
        logic [2:0] inversion;
    } t_cfg;

    // Queue entry between the front and the back.
    typedef struct packed {
        logic [KEY_W-1:0] note;
        logic             close;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_COLLECT,
        ST_EXPAND,
        ST_SORT,
        ST_EMIT
    } t_state;

    // Interval of chord entry idx for a chord type; unused codes act as major.
    function automatic logic [3:0] chord_interval(input logic [2:0] ty, input logic [1:0] idx);
        logic [3:0] r;
        r = 4'd0;
        case (idx)
            2'd0: r = 4'd0;
            2'd1: begin
                if (ty == 3'd1 || ty == 3'd5) r = 4'd3;
                else if (ty == 3'd2) r = 4'd2;
                else if (ty == 3'd3) r = 4'd5;
                else r = 4'd4;
            end
            2'd2: r = 4'd7;
            2'd3: r = 4'd10;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== hw/rtl/cne_front.sv =====
module cne_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic [15:0]              i_note,
    input  logic                     i_end,
    input  logic                     i_empty,
    output logic                     o_push,
    output cne_pkg::t_cmd            o_cmd,
    output logic                     o_flush,
    input  logic                     i_full
);
    import cne_pkg::*;

    // Classify: an empty-list item flushes the collection, others push.
    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full && !i_empty;
    assign o_flush  = i_valid && !i_full && i_empty;
    assign o_cmd.note  = i_note;
    assign o_cmd.close = i_end;

endmodule

// ===== hw/rtl/cne_queue.sv =====
module cne_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cne_pkg::t_cmd i_cmd,
    input  logic          i_flush,
    output logic          o_full,
    output logic          o_valid,
    output cne_pkg::t_cmd o_cmd,
    output logic          o_flush,
    input  logic          i_pop
);
    import cne_pkg::*;

    // Two-entry queue; flush is a command entry with its own marker.
    typedef struct packed {
        t_cmd cmd;
        logic flush;
    } t_ent;

    t_ent       r_mem [2];
    logic       r_wp, n_wp, r_rp, n_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       w_wr;

    assign w_wr    = (i_push || i_flush) && !o_full;
    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_cmd.note  = r_mem[r_rp].cmd.note;
    assign o_cmd.close = r_mem[r_rp].cmd.close || r_mem[r_rp].flush;
    assign o_flush     = r_mem[r_rp].flush;

    always_comb begin
        n_wp  = r_wp ^ w_wr;
        n_rp  = r_rp ^ (i_pop && o_valid);
        n_cnt = r_cnt + {1'b0, w_wr} - {1'b0, i_pop && o_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            r_wp <= n_wp; r_rp <= n_rp; r_cnt <= n_cnt;
        end
        if (w_wr) begin
            r_mem[r_wp].cmd   <= i_cmd;
            r_mem[r_wp].flush <= i_flush;
        end
    end

`ifndef SYNTHESIS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt <= 2'd2)
        else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |=> r_cnt >= 2'd1) else $error("queue lost entries");
    a_empty_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_wr) |=> r_cnt == 2'd0) else $error("queue count drift");
`endif
endmodule

// ===== hw/rtl/cne_back.sv =====
module cne_back #(
    parameter int MAX_KEYS = cne_pkg::MAX_KEYS_D
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  cne_pkg::t_cfg i_cfg,
    input  logic          i_valid,
    input  cne_pkg::t_cmd i_cmd,
    input  logic          i_flush,
    output logic          o_pop,
    output logic          o_busy,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [15:0]   o_note,
    output logic          o_last
);
    import cne_pkg::*;

    localparam int AW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [15:0] r_held [MAX_KEYS];
    logic [15:0] r_nts  [MAX_KEYS];
    logic [CW-1:0] r_hcnt, n_hcnt, r_ncnt, n_ncnt;
    logic [CW-1:0] r_k, n_k, r_i, n_i, r_j, n_j;
    logic [1:0]  r_c, n_c;
    t_state      r_st, n_st;
    logic        r_ov, n_ov;
    logic [15:0] r_on;
    logic        r_ol;

    // Chord entry under construction.
    logic [2:0]  w_ty;
    logic [2:0]  w_size;
    logic [2:0]  w_inv;
    logic [15:0] w_root, w_ent;
    logic [15:0] w_e [4];
    logic [1:0]  w_rank [4];
    logic        w_wr_n;
    logic [AW-1:0] w_wa;
    logic [15:0] w_wd;
    logic        w_swap;
    logic [15:0] w_ai, w_aj;

    assign w_ty   = (i_cfg.ctype <= 3'd5) ? i_cfg.ctype : 3'd0;
    assign w_size = (w_ty >= 3'd4) ? 3'd4 : 3'd3;
    assign w_inv  = (i_cfg.inversion < w_size) ? i_cfg.inversion : w_size;
    assign w_root = r_held[r_k[AW-1:0]];
    assign w_ai   = r_nts[r_i[AW-1:0]];
    assign w_aj   = r_nts[r_j[AW-1:0]];

    // Build every entry of the current chord, rank them, and pick the r_c-th
    // smallest so that a chord cut short at the cap keeps its lowest notes.
    always_comb begin
        for (int a = 0; a < 4; a++) begin
            w_e[a] = w_root + {12'd0, chord_interval(w_ty, 2'(a))};
            if (a != 0) w_e[a] = w_e[a] + 16'(12 * i_cfg.spread);
            if (3'(a) < w_inv) w_e[a] = w_e[a] + 16'd12;
        end
        for (int a = 0; a < 4; a++) begin
            w_rank[a] = 2'd0;
            for (int b = 0; b < 4; b++)
                if (b != a && 3'(b) < w_size &&
                    (w_e[b] < w_e[a] || (w_e[b] == w_e[a] && b < a)))
                    w_rank[a] = w_rank[a] + 2'd1;
        end
        w_ent = w_e[0];
        for (int a = 0; a < 4; a++)
            if (3'(a) < w_size && w_rank[a] == r_c) w_ent = w_e[a];
    end

    assign o_busy  = r_st != ST_COLLECT;
    assign o_valid = r_ov;
    assign o_note  = r_on;
    assign o_last  = r_ol;

    always_comb begin
        n_st = r_st; n_hcnt = r_hcnt; n_ncnt = r_ncnt;
        n_k = r_k; n_i = r_i; n_j = r_j; n_c = r_c;
        n_ov = r_ov && !i_ready;
        o_pop = 1'b0; w_wr_n = 1'b0; w_wa = r_ncnt[AW-1:0]; w_wd = w_ent;
        w_swap = 1'b0;
        case (r_st)
            ST_COLLECT: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    if (i_flush) n_hcnt = '0;
                    else begin
                        if (r_hcnt < CW'(MAX_KEYS)) n_hcnt = r_hcnt + 1'b1;
                        if (i_cmd.close) begin
                            n_st = ST_EXPAND; n_k = '0; n_c = '0; n_ncnt = '0;
                        end
                    end
                end
            end
            ST_EXPAND: begin
                // One chord entry (or one held key) a cycle.
                if (r_k >= r_hcnt || r_ncnt >= CW'(MAX_KEYS)) begin
                    n_st = ST_SORT; n_i = '0; n_j = CW'(1); n_hcnt = '0;
                end else if (!i_cfg.enabled) begin
                    w_wr_n = 1'b1; w_wd = w_root;
                    n_ncnt = r_ncnt + 1'b1; n_k = r_k + 1'b1;
                end else begin
                    w_wr_n = 1'b1;
                    n_ncnt = r_ncnt + 1'b1;
                    if ({1'b0, r_c} == w_size - 3'd1) begin
                        n_c = '0; n_k = r_k + 1'b1;
                    end else n_c = r_c + 1'b1;
                end
            end
            ST_SORT: begin
                // Exchange sort, if enabled, over all notes; sorted notes stay put.
                if (!i_cfg.enabled || r_i >= r_ncnt) begin
                    n_st = ST_EMIT; n_i = '0;
                end else if (r_j >= r_ncnt) begin
                    n_i = r_i + 1'b1; n_j = r_i + 2'd2;
                end else begin
                    w_swap = w_aj < w_ai;
                    n_j = r_j + 1'b1;
                end
            end
            ST_EMIT: begin
                if (r_i >= r_ncnt) n_st = ST_COLLECT;
                else if (!r_ov || i_ready) begin
                    n_ov = 1'b1; n_i = r_i + 1'b1;
                end
            end
            default: n_st = ST_COLLECT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_COLLECT; r_hcnt <= '0; r_ncnt <= '0; r_ov <= 1'b0;
            r_k <= '0; r_i <= '0; r_j <= '0; r_c <= '0;
        end else begin
            r_st <= n_st; r_hcnt <= n_hcnt; r_ncnt <= n_ncnt; r_ov <= n_ov;
            r_k <= n_k; r_i <= n_i; r_j <= n_j; r_c <= n_c;
        end
        if (r_st == ST_COLLECT && i_valid && !i_flush && r_hcnt < CW'(MAX_KEYS))
            r_held[r_hcnt[AW-1:0]] <= i_cmd.note;
        if (w_wr_n) r_nts[w_wa] <= w_wd;
        if (w_swap) begin
            r_nts[r_i[AW-1:0]] <= w_aj;
            r_nts[r_j[AW-1:0]] <= w_ai;
        end
        if (r_st == ST_EMIT && r_i < r_ncnt && (!r_ov || i_ready)) begin
            r_on <= r_nts[r_i[AW-1:0]];
            r_ol <= (r_i + 1'b1) == r_ncnt;
        end
    end

`ifndef SYNTHESIS
    a_hcnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hcnt <= CW'(MAX_KEYS)) else $error("held count overflow");
    a_ncnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ncnt <= CW'(MAX_KEYS)) else $error("note count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !i_ready) |=> (r_ov && $stable(r_on))) else $error("output lost");
`endif
endmodule

// ===== hw/rtl/chord_note_expander.sv =====
// Channel    | Direction | Transfer carries
// s_axis     | in        | tdata[15:0] key_note; tlast list_end; tuser list_empty
// m_axis     | out       | tdata[15:0] out_note; tlast out_last
// cfg        | in        | i_cfg_idx register index, i_cfg_data value
// A closing key starts expansion, one chord note or held key per cycle (up to MAX_KEYS), then an
// exchange sort when enabled, then one note per cycle while m_axis is ready.
// Keys between lists pass through the two-entry queue.
// Reset clears counts and state; stores are undefined until written.
// A stalled m_axis holds the output register and stops emission of further notes.
module chord_note_expander #(
    parameter int MAX_KEYS = cne_pkg::MAX_KEYS_D
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] key_note
    input  logic        s_axis_tlast,
    input  logic        s_axis_tuser,   // [0] list_empty
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] out_note
    output logic        m_axis_tlast,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);
    import cne_pkg::*;

    t_cfg r_cfg;
    t_cmd w_fcmd, w_qcmd;
    logic w_push, w_flush, w_full, w_qv, w_pop, w_busy;
    logic w_qflush;

    assign o_cfg_ready = 1'b1;

    // Hold configuration; writes must arrive only while idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cfg <= '0;
        else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_ENABLED:   r_cfg.enabled   <= i_cfg_data[0];
                REG_TYPE:      r_cfg.ctype     <= i_cfg_data[2:0];
                REG_SPREAD:    r_cfg.spread    <= i_cfg_data[1:0];
                REG_INVERSION: r_cfg.inversion <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    cne_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_note(s_axis_tdata), .i_end(s_axis_tlast), .i_empty(s_axis_tuser),
        .o_push(w_push), .o_cmd(w_fcmd), .o_flush(w_flush), .i_full(w_full)
    );

    // Flush entries are marked by carrying the empty flag in each queue entry.
    cne_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(w_push), .i_cmd(w_fcmd), .i_flush(w_flush), .o_full(w_full),
        .o_valid(w_qv), .o_cmd(w_qcmd), .o_flush(w_qflush), .i_pop(w_pop)
    );

    cne_back #(.MAX_KEYS(MAX_KEYS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg),
        .i_valid(w_qv), .i_cmd(w_qcmd), .i_flush(w_qflush),
        .o_pop(w_pop), .o_busy(w_busy),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_note(m_axis_tdata), .o_last(m_axis_tlast)
    );

`ifndef SYNTHESIS
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv) else $error("pop from empty queue");
    a_busy_nopop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !w_pop) else $error("pop while busy");
    a_out_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid) else $error("result dropped");
`endif
endmodule
